@@ hdl/lps_pkg.sv @@
// ----------------------------------------------------------------------------
// Leibniz partial sum package
// Widths, register codes and controller states shared by the partial sum
// unit and its channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package lps_pkg;

  // Field and datapath widths.
  localparam int IndexBits   = 24;
  localparam int FracBits    = 32;
  localparam int AccBits     = 40;
  localparam int StrideBits  = 11;
  localparam int StartBits   = 10;

  // The quotient 2^FracBits / (2i+1) needs one bit above the fraction.
  localparam int QuotBits    = FracBits + 1;
  // Odd denominator 2i+1 for any included term index.
  localparam int DenBits     = IndexBits + 1;
  // The running term index may step one stride past the last index.
  localparam int IdxRegBits  = IndexBits + 1;
  localparam int CntBits     = $clog2(QuotBits);

  // Configuration channel.
  localparam int CfgIdxBits  = 2;
  localparam int CfgDataBits = StrideBits;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgStride = 2'd0,
    CfgStart  = 2'd1
  } cfg_reg_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_ADD,
    S_OUT
  } state_e;

endpackage

`default_nettype wire

@@ hdl/lps_in_if.sv @@
// ----------------------------------------------------------------------------
// Input channel
// Carries one upper term index per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface lps_in_if;
  logic                         valid;
  logic                         ready;
  logic [lps_pkg::IndexBits-1:0] last_index;

  modport source (output valid, output last_index, input ready);
  modport sink   (input valid, input last_index, output ready);
endinterface

`default_nettype wire

@@ hdl/lps_out_if.sv @@
// ----------------------------------------------------------------------------
// Result channel
// Carries one signed fixed-point partial sum per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface lps_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [lps_pkg::AccBits-1:0] pi_part;

  modport source (output valid, output pi_part, input ready);
  modport sink   (input valid, input pi_part, output ready);
endinterface

`default_nettype wire

@@ hdl/lps_cfg_if.sv @@
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries a register index and its write data per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface lps_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lps_pkg::CfgIdxBits-1:0]  reg_idx;
  logic [lps_pkg::CfgDataBits-1:0] wdata;

  modport source (output valid, output reg_idx, output wdata, input ready);
  modport sink   (input valid, input reg_idx, input wdata, output ready);
endinterface

`default_nettype wire

@@ hdl/leibniz_pi_partial_sum_unit.sv @@
// ----------------------------------------------------------------------------
// Leibniz partial sum unit
// Sums the strided terms (-1)^i / (2i+1) from the start index up to the
// given last index and returns four times the sum, 32 fraction bits.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload                    Beat
//   in_i     sink       last_index[23:0]           one series request
//   out_o    source     pi_part[39:0], signed      one partial sum
//   cfg_i    sink       reg_idx[1:0], wdata[10:0]  one register write
//
// Each term runs an index check, a bit-serial restoring divider producing one
// quotient bit per cycle, and an add. A new request is taken only in the idle
// state, once the previous result has been loaded into the output register.
// Reset sets stride to 1 and start index to 0; configuration is always ready.
// A stalled result holds the unit in its output state until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module leibniz_pi_partial_sum_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lps_in_if.sink     in_i,
  lps_out_if.source  out_o,
  lps_cfg_if.sink    cfg_i
);

  lps_pkg::state_e state_q, state_d;

  logic [lps_pkg::StrideBits-1:0] stride_q;
  logic [lps_pkg::StartBits-1:0]  start_q;

  logic [lps_pkg::IndexBits-1:0]  last_q;
  logic [lps_pkg::IdxRegBits-1:0] idx_q;
  logic [lps_pkg::StrideBits-1:0] step_q;
  logic [lps_pkg::AccBits-1:0]    acc_q;
  logic [lps_pkg::DenBits-1:0]    rem_q;
  logic [lps_pkg::QuotBits-1:0]   quot_q;
  logic [lps_pkg::CntBits-1:0]    cnt_q;
  logic signed [lps_pkg::AccBits-1:0] pi_part_q;
  logic                           out_valid_q;

  logic                           in_take;
  logic                           out_free;
  logic                           past_last;
  logic                           div_start;
  logic                           div_last;
  logic                           load_out;
  logic [lps_pkg::DenBits-1:0]    den;
  logic [lps_pkg::DenBits:0]      rem_sh;
  logic                           quot_bit;
  logic [lps_pkg::DenBits-1:0]    rem_d;
  logic [lps_pkg::AccBits-1:0]    mag;
  logic [lps_pkg::AccBits-1:0]    term;

  // Configuration registers; writes are taken in every cycle.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q <= lps_pkg::StrideBits'(1);
      start_q  <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.reg_idx)
        lps_pkg::CfgStride: stride_q <= cfg_i.wdata[lps_pkg::StrideBits-1:0];
        lps_pkg::CfgStart:  start_q  <= cfg_i.wdata[lps_pkg::StartBits-1:0];
        default: ;
      endcase
    end
  end

  // Handshake and status terms.
  assign in_take   = in_i.valid && in_i.ready;
  assign out_free  = !out_valid_q || out_o.ready;
  assign past_last = idx_q > lps_pkg::IdxRegBits'(last_q);
  assign div_last  = cnt_q == lps_pkg::CntBits'(lps_pkg::QuotBits - 1);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lps_pkg::S_IDLE:  if (in_i.valid) state_d = lps_pkg::S_CHECK;
      lps_pkg::S_CHECK: state_d = past_last ? lps_pkg::S_OUT : lps_pkg::S_DIV;
      lps_pkg::S_DIV:   if (div_last) state_d = lps_pkg::S_ADD;
      lps_pkg::S_ADD:   state_d = lps_pkg::S_CHECK;
      lps_pkg::S_OUT:   if (out_free) state_d = lps_pkg::S_IDLE;
      default:          state_d = lps_pkg::S_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_i.ready = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      lps_pkg::S_IDLE:  in_i.ready = 1'b1;
      lps_pkg::S_CHECK: div_start  = !past_last;
      lps_pkg::S_OUT:   load_out   = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lps_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Divider step: shift in one dividend bit (the leading one of 2^FracBits,
  // then zeros) and subtract the odd denominator where it fits.
  assign den      = {idx_q[lps_pkg::IndexBits-1:0], 1'b1};
  assign rem_sh   = {rem_q, cnt_q == '0};
  assign quot_bit = rem_sh >= {1'b0, den};
  assign rem_d    = quot_bit ? lps_pkg::DenBits'(rem_sh - {1'b0, den})
                             : rem_sh[lps_pkg::DenBits-1:0];

  // Signed term, negated for odd indices.
  assign mag  = lps_pkg::AccBits'(quot_q);
  assign term = idx_q[0] ? lps_pkg::AccBits'(-mag) : mag;

  // Divider bit counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (div_start) begin
      cnt_q <= '0;
    end else if (state_q == lps_pkg::S_DIV) begin
      cnt_q <= lps_pkg::CntBits'(cnt_q + 1'b1);
    end
  end

  // Series datapath: index walk, divider registers and accumulator.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      last_q <= in_i.last_index;
      idx_q  <= lps_pkg::IdxRegBits'(start_q);
      acc_q  <= '0;
      step_q <= (stride_q == '0) ? lps_pkg::StrideBits'(1) : stride_q;
    end
    if (div_start) begin
      rem_q <= '0;
    end else if (state_q == lps_pkg::S_DIV) begin
      rem_q  <= rem_d;
      quot_q <= {quot_q[lps_pkg::QuotBits-2:0], quot_bit};
    end
    if (state_q == lps_pkg::S_ADD) begin
      acc_q <= lps_pkg::AccBits'(acc_q + term);
      idx_q <= lps_pkg::IdxRegBits'(idx_q + lps_pkg::IdxRegBits'(step_q));
    end
  end

  // Output register: holds the result until the beat completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      pi_part_q <= {acc_q[lps_pkg::AccBits-3:0], 2'b00};
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.pi_part = pi_part_q;

  // The partial remainder stays below the denominator throughout a division.
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lps_pkg::S_DIV) |-> (rem_q < den))
    else $error("divider remainder not below denominator");

  // The last divider step is always followed by the add.
  a_div_to_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lps_pkg::S_DIV && div_last) |=> (state_q == lps_pkg::S_ADD))
    else $error("division did not end in the add step");

  // An accepted beat always begins with an index check.
  a_take_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> (state_q == lps_pkg::S_CHECK))
    else $error("accepted beat not followed by index check");

  // A new result only appears from the output state.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == lps_pkg::S_OUT))
    else $error("result raised outside the output state");

  // Only the index check may start a division.
  a_div_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lps_pkg::S_DIV && cnt_q == '0) |-> $past(state_q == lps_pkg::S_CHECK))
    else $error("division started without index check");

endmodule

`default_nettype wire
